// File: hw/rtl/min_max_partition_search_assert.svh
// ----------------------------------------------------------------------------
// min_max_partition_search assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MIN_MAX_PARTITION_SEARCH_ASSERT_SVH
`define MIN_MAX_PARTITION_SEARCH_ASSERT_SVH

// same-cycle implication
`define MMPS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mmps assertion failed");

// next-cycle implication
`define MMPS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mmps assertion failed");

`endif

// File: hw/rtl/mmps_pkg.sv
// ----------------------------------------------------------------------------
// mmps_pkg
// Transaction types, register map and constants of the partition search.
// ----------------------------------------------------------------------------
`default_nettype none

package mmps_pkg;

	localparam int ADDR_W = 3;
	localparam int LIMIT_W = 7;
	localparam int RESULT_W = 22;
	localparam logic [0:0] REG_GROUP_LIMIT = 1'b0;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd1;
	localparam logic [RESULT_W-1:0] SUM_MAX = 22'h3FFFFF;

	typedef struct packed {
		logic [15:0] weight;
		logic        last_item;
	} item_t;

	typedef struct packed {
		logic [RESULT_W-1:0] min_max_sum;
		logic                overflowed;
	} result_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic overflowed;
	} srch_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/min_max_partition_search.sv
// A data set is searched with at most P = ceil(log2(total - largest + 2)) probes.
// Throughput: items load one per cycle while the search is idle (busy low); busy
// stays high for the whole search, set by the single add/compare walk over the
// item store, one item a cycle.
// The result strobe (done) lasts one cycle; the receiver cannot stall it.
// Reset (arst_n, async low) empties the data set and sets group_limit to 1.
// ----------------------------------------------------------------------------
// min_max_partition_search
// Smallest largest-group sum over contiguous splits, by binary search with
// greedy probes; APB register for the group limit.
// ----------------------------------------------------------------------------
`default_nettype none

module min_max_partition_search #(
	parameter int MAX_ITEMS   = 64,
	parameter int WEIGHT_BITS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire mmps_pkg::item_t              item,
	output logic                              done,
	output mmps_pkg::result_t                 result,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [mmps_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);
	import mmps_pkg::*;

	localparam int SUM_W = WEIGHT_BITS + $clog2(MAX_ITEMS + 1);
	localparam int EXT_W = (SUM_W > RESULT_W) ? SUM_W : RESULT_W;

	logic [LIMIT_W-1:0] limit_q;
	logic               done_q;
	result_t            result_q;
	srch_stat_t         stat;
	logic [SUM_W-1:0]   bound;
	logic [EXT_W-1:0]   bound_ext;
	logic               accept;
	logic               reg_sel;

	assign accept = start && !stat.busy;
	assign reg_sel = (paddr[ADDR_W-1] == REG_GROUP_LIMIT);

	mmps_search #(
		.MAX_ITEMS  (MAX_ITEMS),
		.WEIGHT_BITS(WEIGHT_BITS),
		.SUM_W      (SUM_W)
	) u_search (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (item),
		.group_limit(limit_q),
		.stat       (stat),
		.bound      (bound)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = reg_sel ? {{(32-LIMIT_W){1'b0}}, limit_q} : 32'd0;

	// widen the bound for the saturating compare against the result field
	assign bound_ext = EXT_W'(bound);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= stat.done;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			result_q.min_max_sum <= (bound_ext > EXT_W'(SUM_MAX)) ? SUM_MAX
				: bound_ext[RESULT_W-1:0];
			result_q.overflowed <= stat.overflowed;
		end
	end

	assign busy = stat.busy;
	assign done = done_q;
	assign result = result_q;

endmodule

`default_nettype wire

// File: hw/rtl/mmps_search.sv
// ----------------------------------------------------------------------------
// mmps_search
// Item store, load statistics and the binary search sequencer. One shared
// add/compare datapath walks the store, at most once per probe.
// ----------------------------------------------------------------------------
`default_nettype none

module mmps_search #(
	parameter int MAX_ITEMS   = 64,
	parameter int WEIGHT_BITS = 16,
	parameter int SUM_W       = 23
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        accept,
	input  wire mmps_pkg::item_t             item,
	input  wire logic [mmps_pkg::LIMIT_W-1:0] group_limit,
	output mmps_pkg::srch_stat_t             stat,
	output logic [SUM_W-1:0]                 bound
);
	import mmps_pkg::*;

	`include "min_max_partition_search_assert.svh"

	localparam int IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_WALK  = 2'd2;

	logic [WEIGHT_BITS-1:0] mem [MAX_ITEMS];
	logic [WEIGHT_BITS-1:0] rd_data_q;
	logic [IDX_W-1:0]       rd_addr;

	logic [1:0]             state_q;
	logic [CNT_W-1:0]       count_q;
	logic [SUM_W-1:0]       total_q;
	logic [WEIGHT_BITS-1:0] max_q;
	logic                   drop_q;
	logic [SUM_W-1:0]       low_q, high_q, mid_q, best_q, run_q;
	logic [LIMIT_W:0]       groups_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   done_q, ovf_q;

	logic [WEIGHT_BITS-1:0] w_in;
	logic                   room;
	logic [SUM_W-1:0]       total_nxt;
	logic [WEIGHT_BITS-1:0] max_nxt;
	logic [SUM_W-1:0]       sum;
	logic                   over, fail, last_k, walk_end;
	logic [LIMIT_W:0]       grp_inc;

	assign w_in = WEIGHT_BITS'(item.weight);
	assign room = count_q < CNT_W'(MAX_ITEMS);
	assign total_nxt = room ? total_q + SUM_W'(w_in) : total_q;
	assign max_nxt = (room && w_in > max_q) ? w_in : max_q;

	// shared walk datapath
	assign sum = run_q + SUM_W'(rd_data_q);
	assign over = sum > mid_q;
	assign grp_inc = groups_q + 1'b1;
	assign fail = over && (grp_inc > {1'b0, group_limit});
	assign last_k = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
	assign walk_end = fail || last_k;

	// item 0 is prefetched while the midpoint is formed
	assign rd_addr = (state_q == ST_CHECK) ? '0 : idx_q + 1'b1;

	always_ff @(posedge clk) begin
		if (accept && room) begin
			mem[count_q[IDX_W-1:0]] <= w_in;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			total_q  <= '0;
			max_q    <= '0;
			drop_q   <= 1'b0;
			low_q    <= '0;
			high_q   <= '0;
			mid_q    <= '0;
			best_q   <= '0;
			run_q    <= '0;
			groups_q <= '0;
			idx_q    <= '0;
			done_q   <= 1'b0;
			ovf_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (room) begin
							count_q <= count_q + 1'b1;
						end else begin
							drop_q <= 1'b1;
						end
						total_q <= total_nxt;
						max_q <= max_nxt;
						if (item.last_item) begin
							low_q   <= SUM_W'(max_nxt);
							high_q  <= total_nxt;
							best_q  <= SUM_W'(max_nxt);
							ovf_q   <= drop_q || !room;
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (low_q > high_q) begin
						done_q  <= 1'b1;
						count_q <= '0;
						total_q <= '0;
						max_q   <= '0;
						drop_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						mid_q    <= SUM_W'(({1'b0, low_q} + {1'b0, high_q}) >> 1);
						run_q    <= '0;
						groups_q <= (LIMIT_W+1)'(1);
						idx_q    <= '0;
						state_q  <= ST_WALK;
					end
				end
				ST_WALK: begin
					idx_q <= idx_q + 1'b1;
					if (over) begin
						run_q    <= SUM_W'(rd_data_q);
						groups_q <= grp_inc;
					end else begin
						run_q <= sum;
					end
					if (walk_end) begin
						state_q <= ST_CHECK;
						if (!fail) begin
							best_q <= mid_q;
							if (mid_q == '0) begin
								// zero bound fits: nothing smaller to try
								done_q  <= 1'b1;
								count_q <= '0;
								total_q <= '0;
								max_q   <= '0;
								drop_q  <= 1'b0;
								state_q <= ST_IDLE;
							end else begin
								high_q <= mid_q - 1'b1;
							end
						end else begin
							low_q <= mid_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = done_q;
	assign stat.overflowed = ovf_q;
	assign bound = best_q;

	`MMPS_ASSERT_NOW(a_done_idle, done_q, state_q == ST_IDLE)
	`MMPS_ASSERT_NEXT(a_last_starts, accept && item.last_item, state_q == ST_CHECK)
	`MMPS_ASSERT_NOW(a_walk_in_range, state_q == ST_WALK, CNT_W'(idx_q) < count_q)
	`MMPS_ASSERT_NOW(a_groups_bound, state_q == ST_WALK, (groups_q <= {1'b0, group_limit}) || (groups_q == (LIMIT_W+1)'(1)))

endmodule

`default_nettype wire
